// ===== hdl/sbc_pkg.sv =====
`timescale 1ns / 1ps

package sbc_pkg;

   // Default sizes of the graph stores and of the fixed-point fraction.
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int MAX_EDGES_DEF    = 8192;
   localparam int FRAC_BITS_DEF    = 16;

   // Field widths of the command and result beats.
   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 13;
   localparam int WORD_W   = 14;
   localparam int VERTEX_W = 10;
   localparam int VCOUNT_W = 11;
   localparam int SCORE_W  = 48;
   localparam int STATUS_W = 2;
   localparam int PATH_W   = 32;
   localparam int RUNS_W   = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_LOAD_ROW  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_EDGE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RUN       = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SAT   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NORUN = 2'd3;

   // Register index taken from the word address.
   localparam logic CSR_VERTEX_COUNT = 1'b0;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_INIT,
      S_SEED,
      S_B_POP,
      S_B_V,
      S_B_LO,
      S_B_HI,
      S_B_EDGE,
      S_B_U,
      S_B_UD,
      S_R_POP,
      S_R_V,
      S_R_LO,
      S_R_HI,
      S_R_EDGE,
      S_R_U,
      S_R_UD,
      S_MUL_LO,
      S_MUL_HI,
      S_DIV,
      S_DIV_DONE,
      S_ACC_RD,
      S_ACC_WR,
      S_RD_WAIT
   } state_type;

   function automatic logic [SCORE_W-1:0] sat_add48(input logic [SCORE_W-1:0] a,
                                                    input logic [SCORE_W-1:0] b);
      logic [SCORE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SCORE_W] ? '1 : s[SCORE_W-1:0];
   endfunction

endpackage

// ===== hdl/sbc_ram.sv =====
`timescale 1ns / 1ps

module sbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sampled_betweenness_centrality.sv =====
// Channel     Ports                                         Handshake
// command     req_action, req_slot, req_word, req_vertex    start high while busy low
// result      rsp_score, rsp_status                         rsp_valid, one cycle, no stall
// registers   psel, penable, pwrite, paddr, pwdata, prdata  APB write, pready tied high
//
// Loads and bad commands answer in the cycle after the beat; busy stays low.
// A read forms two partial products, then runs a one bit per cycle divider
// on an 81-bit dividend.
// A run clears the n vertices in use, does the search, then the dependency
// pass, where shortest edges go through the shared divider, and then folds
// the dependencies into the scores.
// Reset and a clear command sweep the score memory with busy high.
// The result side cannot stall.
`timescale 1ns / 1ps

module sampled_betweenness_centrality
   import sbc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [WORD_W-1:0]   req_word,
   input  logic [VERTEX_W-1:0] req_vertex,
   output logic                rsp_valid,
   output logic [SCORE_W-1:0]  rsp_score,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   localparam int VW   = $clog2(MAX_VERTICES);
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int DW   = VW + 1;
   localparam int RAW  = $clog2(MAX_VERTICES + 1);
   localparam int EW   = $clog2(MAX_EDGES + 1);
   localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NUMW = SCORE_W + 1;
   localparam int PW   = NUMW + PATH_W;
   localparam int CW   = $clog2(PW);
   localparam logic [NUMW-1:0] ONE = NUMW'(1) << FRAC_BITS;

   // Control and datapath registers.
   state_type               state_ff, state_in;
   logic [NW-1:0]           k_ff, k_in;
   logic [NW-1:0]           front_ff, front_in;
   logic [NW-1:0]           back_ff, back_in;
   logic [VW-1:0]           src_ff, src_in;
   logic [VW-1:0]           v_ff, v_in;
   logic [VW-1:0]           u_ff, u_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [PATH_W-1:0]       pv_ff, pv_in;
   logic [EW-1:0]           j_ff, j_in;
   logic [EW-1:0]           hi_ff, hi_in;
   logic [SCORE_W-1:0]      acc_ff, acc_in;
   logic                    sat_ff, sat_in;
   logic [NUMW-1:0]         num_ff, num_in;
   logic [PATH_W-1:0]       q_ff, q_in;
   logic [PW-1:0]           div_ff, div_in;
   logic [PATH_W:0]         rem_ff, rem_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    rd_mode_ff, rd_mode_in;
   logic [RUNS_W-1:0]       runs_ff, runs_in;
   logic [VCOUNT_W-1:0]     vc_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]      rsp_score_ff, rsp_score_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                    row_we;
   logic [RAW-1:0]          row_wa, row_ra;
   logic [WORD_W-1:0]       row_wd, row_rd;
   logic                    edge_we;
   logic [EAW-1:0]          edge_wa, edge_ra;
   logic [VW-1:0]           edge_wd, edge_rd;
   logic                    dist_we;
   logic [VW-1:0]           dist_wa, dist_ra;
   logic [DW:0]             dist_wd, dist_rd;
   logic                    pc_we;
   logic [VW-1:0]           pc_wa, pc_ra;
   logic [PATH_W-1:0]       pc_wd, pc_rd;
   logic                    dep_we;
   logic [VW-1:0]           dep_wa, dep_ra;
   logic [SCORE_W-1:0]      dep_wd, dep_rd;
   logic                    vo_we;
   logic [VW-1:0]           vo_wa, vo_ra;
   logic [VW-1:0]           vo_wd, vo_rd;
   logic                    bc_we;
   logic [VW-1:0]           bc_wa, bc_ra;
   logic [SCORE_W-1:0]      bc_wd, bc_rd;

   // Helpers.
   logic [NW-1:0]           n_w;
   logic [NW-1:0]           back_m1;
   logic [EW-1:0]           row_clip;
   logic [PATH_W:0]         pc_sum;
   logic [PATH_W:0]         rem_sh;
   logic                    div_ge;
   logic [SCORE_W-1:0]      quo_sat;
   logic                    u_seen;
   logic                    u_next;
   logic                    csr_write;

   // Effective vertex count: clamp the register into 1..MAX_VERTICES.
   always_comb begin
      if (vc_ff == '0) begin
         n_w = NW'(1);
      end else if (32'(vc_ff) > MAX_VERTICES) begin
         n_w = NW'(MAX_VERTICES);
      end else begin
         n_w = NW'(vc_ff);
      end
   end

   assign back_m1  = back_ff - NW'(1);
   assign row_clip = (32'(row_rd) > MAX_EDGES) ? EW'(MAX_EDGES) : EW'(row_rd);
   assign pc_sum   = {1'b0, pc_rd} + {1'b0, pv_ff};
   assign rem_sh   = {rem_ff[PATH_W-1:0], div_ff[PW-1]};
   assign div_ge   = rem_sh >= {1'b0, q_ff};
   assign quo_sat  = (|div_ff[PW-1:SCORE_W]) ? '1 : div_ff[SCORE_W-1:0];
   assign u_seen   = dist_rd[DW];
   assign u_next   = dist_rd[DW-1:0] == d_ff + DW'(1);

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      src_in        = src_ff;
      v_in          = v_ff;
      u_in          = u_ff;
      d_in          = d_ff;
      pv_in         = pv_ff;
      j_in          = j_ff;
      hi_in         = hi_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      num_in        = num_ff;
      q_in          = q_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rd_mode_in    = rd_mode_ff;
      runs_in       = runs_ff;
      rsp_valid_in  = 1'b0;
      rsp_score_in  = '0;
      rsp_status_in = STAT_OK;

      row_we  = 1'b0; row_wa  = RAW'(req_slot); row_wd = req_word; row_ra = RAW'(v_ff);
      edge_we = 1'b0; edge_wa = EAW'(req_slot); edge_wd = VW'(req_word);
      edge_ra = j_ff[EAW-1:0];
      dist_we = 1'b0; dist_wa = u_ff; dist_wd = '0; dist_ra = u_ff;
      pc_we   = 1'b0; pc_wa   = u_ff; pc_wd   = '0; pc_ra   = u_ff;
      dep_we  = 1'b0; dep_wa  = v_ff; dep_wd  = acc_ff; dep_ra = u_ff;
      vo_we   = 1'b0; vo_wa   = back_ff[VW-1:0]; vo_wd = u_ff; vo_ra = front_ff[VW-1:0];
      bc_we   = 1'b0; bc_wa   = k_ff[VW-1:0]; bc_wd = '0; bc_ra = k_ff[VW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            bc_we = 1'b1;
            if (k_ff == NW'(MAX_VERTICES - 1)) begin
               k_in     = '0;
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + NW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_action)
                  ACT_LOAD_ROW: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_slot) > MAX_VERTICES) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        row_we = 1'b1;
                     end
                  end
                  ACT_LOAD_EDGE: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_slot) >= MAX_EDGES || 32'(req_word) >= MAX_VERTICES) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        edge_we = 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     if (32'(req_vertex) >= 32'(n_w)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        src_in   = VW'(req_vertex);
                        k_in     = '0;
                        sat_in   = 1'b0;
                        state_in = S_INIT;
                     end
                  end
                  ACT_READ: begin
                     if (32'(req_vertex) >= 32'(n_w)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_RANGE;
                     end else if (runs_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NORUN;
                     end else begin
                        bc_ra    = VW'(req_vertex);
                        state_in = S_RD_WAIT;
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     runs_in      = '0;
                     k_in         = '0;
                     state_in     = S_CLEAR;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_RANGE;
                  end
               endcase
            end
         end
         // Wipe distance, path count and dependency of the vertices in use.
         S_INIT: begin
            dist_we = 1'b1; dist_wa = k_ff[VW-1:0];
            pc_we   = 1'b1; pc_wa   = k_ff[VW-1:0];
            dep_we  = 1'b1; dep_wa  = k_ff[VW-1:0]; dep_wd = '0;
            if (k_ff == n_w - NW'(1)) begin
               state_in = S_SEED;
            end else begin
               k_in = k_ff + NW'(1);
            end
         end
         S_SEED: begin
            dist_we  = 1'b1; dist_wa = src_ff; dist_wd = {1'b1, DW'(0)};
            pc_we    = 1'b1; pc_wa   = src_ff; pc_wd   = PATH_W'(1);
            vo_we    = 1'b1; vo_wa   = '0;     vo_wd   = src_ff;
            front_in = '0;
            back_in  = NW'(1);
            state_in = S_B_POP;
         end
         // Forward search: pop the queue head.
         S_B_POP: begin
            if (front_ff == back_ff) begin
               state_in = S_R_POP;
            end else begin
               front_in = front_ff + NW'(1);
               state_in = S_B_V;
            end
         end
         S_B_V, S_R_V: begin
            v_in    = vo_rd;
            dist_ra = vo_rd;
            pc_ra   = vo_rd;
            row_ra  = RAW'(vo_rd);
            state_in = (state_ff == S_B_V) ? S_B_LO : S_R_LO;
         end
         S_B_LO, S_R_LO: begin
            d_in   = dist_rd[DW-1:0];
            pv_in  = pc_rd;
            j_in   = row_clip;
            acc_in = '0;
            row_ra = RAW'(v_ff) + RAW'(1);
            state_in = (state_ff == S_B_LO) ? S_B_HI : S_R_HI;
         end
         S_B_HI, S_R_HI: begin
            hi_in    = (row_clip < j_ff) ? j_ff : row_clip;
            state_in = (state_ff == S_B_HI) ? S_B_EDGE : S_R_EDGE;
         end
         S_B_EDGE: begin
            if (j_ff >= hi_ff) begin
               state_in = S_B_POP;
            end else begin
               j_in     = j_ff + EW'(1);
               state_in = S_B_U;
            end
         end
         S_B_U, S_R_U: begin
            u_in    = edge_rd;
            dist_ra = edge_rd;
            pc_ra   = edge_rd;
            dep_ra  = edge_rd;
            if (32'(edge_rd) >= 32'(n_w)) begin
               state_in = (state_ff == S_B_U) ? S_B_EDGE : S_R_EDGE;
            end else begin
               state_in = (state_ff == S_B_U) ? S_B_UD : S_R_UD;
            end
         end
         // Mark a new vertex, then add paths along every shortest edge.
         S_B_UD: begin
            if (!u_seen) begin
               dist_we = 1'b1;
               dist_wd = {1'b1, d_ff + DW'(1)};
               vo_we   = 1'b1;
               back_in = back_ff + NW'(1);
            end
            if (!u_seen || u_next) begin
               pc_we = 1'b1;
               if (pc_sum[PATH_W]) begin
                  pc_wd  = '1;
                  sat_in = 1'b1;
               end else begin
                  pc_wd = pc_sum[PATH_W-1:0];
               end
            end
            state_in = S_B_EDGE;
         end
         // Reverse pass: walk the visit order back to front.
         S_R_POP: begin
            if (back_ff == '0) begin
               k_in     = '0;
               state_in = S_ACC_RD;
            end else begin
               vo_ra    = back_m1[VW-1:0];
               back_in  = back_m1;
               state_in = S_R_V;
            end
         end
         S_R_EDGE: begin
            if (j_ff >= hi_ff) begin
               dep_we   = 1'b1;
               state_in = S_R_POP;
            end else begin
               j_in     = j_ff + EW'(1);
               state_in = S_R_U;
            end
         end
         S_R_UD: begin
            if (u_seen && u_next && pc_rd != '0) begin
               num_in     = ONE + NUMW'(dep_rd);
               q_in       = pc_rd;
               rd_mode_in = 1'b0;
               state_in   = S_MUL_LO;
            end else begin
               state_in = S_R_EDGE;
            end
         end
         // Shared multiply, then restoring divide, one quotient bit a cycle.
         S_MUL_LO: begin
            div_in   = PW'(64'(num_ff[PATH_W-1:0]) * 64'(pv_ff));
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            div_in   = div_ff + (PW'(PW'(num_ff[NUMW-1:PATH_W]) * PW'(pv_ff)) << PATH_W);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = div_ge ? rem_sh - {1'b0, q_ff} : rem_sh;
            div_in = {div_ff[PW-2:0], div_ge};
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = S_DIV_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_DIV_DONE: begin
            if (rd_mode_ff) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = quo_sat;
               state_in     = S_IDLE;
            end else begin
               acc_in   = sat_add48(acc_ff, quo_sat);
               state_in = S_R_EDGE;
            end
         end
         // Fold the dependencies into the scores, skipping the source.
         S_ACC_RD: begin
            if (k_ff == n_w) begin
               if (runs_ff != '1) begin
                  runs_in = runs_ff + RUNS_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_ff ? STAT_SAT : STAT_OK;
               state_in      = S_IDLE;
            end else begin
               dep_ra   = k_ff[VW-1:0];
               state_in = S_ACC_WR;
            end
         end
         S_ACC_WR: begin
            if (k_ff[VW-1:0] != src_ff) begin
               bc_we = 1'b1;
               bc_wd = sat_add48(bc_rd, dep_rd);
            end
            k_in     = k_ff + NW'(1);
            state_in = S_ACC_RD;
         end
         S_RD_WAIT: begin
            num_in     = NUMW'(bc_rd);
            pv_in      = PATH_W'(n_w);
            q_in       = PATH_W'(runs_ff);
            rd_mode_in = 1'b1;
            state_in   = S_MUL_LO;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         k_ff         <= '0;
         front_ff     <= '0;
         back_ff      <= '0;
         sat_ff       <= 1'b0;
         rd_mode_ff   <= 1'b0;
         runs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         sat_ff       <= sat_in;
         rd_mode_ff   <= rd_mode_in;
         runs_ff      <= runs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      v_ff          <= v_in;
      u_ff          <= u_in;
      d_ff          <= d_in;
      pv_ff         <= pv_in;
      j_ff          <= j_in;
      hi_ff         <= hi_in;
      acc_ff        <= acc_in;
      num_ff        <= num_in;
      q_ff          <= q_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Register port: one register, decoded on the word address.
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VCOUNT_W'(1);
      end else if (csr_write && paddr[2] == CSR_VERTEX_COUNT) begin
         vc_ff <= pwdata[VCOUNT_W-1:0];
      end
   end

   assign prdata     = (paddr[2] == CSR_VERTEX_COUNT) ? CSR_DW'(vc_ff) : '0;
   assign pready     = 1'b1;
   assign busy       = state_ff != S_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_score  = rsp_score_ff;
   assign rsp_status = rsp_status_ff;

   sbc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_VERTICES + 1)) u_row_ram (
      .clock(clock), .wr_en(row_we), .wr_addr(row_wa), .wr_data(row_wd),
      .rd_addr(row_ra), .rd_data(row_rd));

   sbc_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd));

   sbc_ram #(.WIDTH(DW + 1), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_wa), .wr_data(dist_wd),
      .rd_addr(dist_ra), .rd_data(dist_rd));

   sbc_ram #(.WIDTH(PATH_W), .DEPTH(MAX_VERTICES)) u_pc_ram (
      .clock(clock), .wr_en(pc_we), .wr_addr(pc_wa), .wr_data(pc_wd),
      .rd_addr(pc_ra), .rd_data(pc_rd));

   sbc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_dep_ram (
      .clock(clock), .wr_en(dep_we), .wr_addr(dep_wa), .wr_data(dep_wd),
      .rd_addr(dep_ra), .rd_data(dep_rd));

   sbc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vo_ram (
      .clock(clock), .wr_en(vo_we), .wr_addr(vo_wa), .wr_data(vo_wd),
      .rd_addr(vo_ra), .rd_data(vo_rd));

   sbc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_VERTICES)) u_bc_ram (
      .clock(clock), .wr_en(bc_we), .wr_addr(bc_wa), .wr_data(bc_wd),
      .rd_addr(bc_ra), .rd_data(bc_rd));

   // The queue head never passes its tail during the search.
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_B_POP || state_ff == S_B_EDGE) |-> front_ff <= back_ff)
      else $error("queue head ran past tail");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      back_ff <= NW'(MAX_VERTICES))
      else $error("queue overflow");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> q_ff != '0)
      else $error("divide by zero");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_action == ACT_CLEAR) |=> state_ff == S_CLEAR)
      else $error("clear did not start sweep");

   a_err_score: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> rsp_score_ff == '0)
      else $error("nonzero score on error");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sbc_pkg::*;

   // Action codes the block does not know; they must answer with a range error.
   localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;
   localparam logic [CSR_AW-1:0]   ADDR_VERTEX_COUNT = 3'd0;

   localparam longint unsigned SCORE_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned PATH_MAX  = 64'h0000_0000_FFFF_FFFF;
   localparam int              CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot;
      logic [WORD_W-1:0]   word;
      logic [VERTEX_W-1:0] vertex;
   } cmd_t;

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [STATUS_W-1:0] status;
   } answer_t;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACTION_W-1:0] req_action;
   logic [SLOT_W-1:0]   req_slot;
   logic [WORD_W-1:0]   req_word;
   logic [VERTEX_W-1:0] req_vertex;
   logic                rsp_valid;
   logic [SCORE_W-1:0]  rsp_score;
   logic [STATUS_W-1:0] rsp_status;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   sampled_betweenness_centrality dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_slot(req_slot), .req_word(req_word),
      .req_vertex(req_vertex), .rsp_valid(rsp_valid), .rsp_score(rsp_score),
      .rsp_status(rsp_status), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow of the block's graph and score stores.
   logic [WORD_W-1:0]   row_shadow [0:MAX_VERTICES_DEF];
   logic [VERTEX_W-1:0] edge_shadow [0:MAX_EDGES_DEF-1];
   int unsigned         hop_dist [0:MAX_VERTICES_DEF-1];
   bit                  reached [0:MAX_VERTICES_DEF-1];
   longint unsigned     sigma [0:MAX_VERTICES_DEF-1];
   longint unsigned     delta [0:MAX_VERTICES_DEF-1];
   int unsigned         bfs_queue [0:MAX_VERTICES_DEF-1];
   longint unsigned     centrality [0:MAX_VERTICES_DEF-1];
   int unsigned         run_total;
   int unsigned         vcount_shadow;

   cmd_t    pending_cmds[$];
   answer_t expected_answers[$];
   int      fail_count;
   int      cycle_count;
   bit      beat_taken;
   int      burst_left;
   int      gap_left;

   // Clock: 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint unsigned sat48(input longint unsigned a,
                                             input longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > SCORE_MAX) ? SCORE_MAX : s;
   endfunction

   function automatic int unsigned active_vertices();
      int unsigned n;
      n = vcount_shadow;
      if (n < 1) n = 1;
      if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
      return n;
   endfunction

   // Clip a vertex's adjacency window to the edge store; a reversed window is empty.
   function automatic void adjacency(input int unsigned v, output int unsigned lo,
                                     output int unsigned hi);
      lo = row_shadow[v];
      hi = row_shadow[v + 1];
      if (lo > MAX_EDGES_DEF) lo = MAX_EDGES_DEF;
      if (hi > MAX_EDGES_DEF) hi = MAX_EDGES_DEF;
      if (hi < lo) hi = lo;
   endfunction

   // floor(p * (1 + dw) / q) in Q32.16, saturated to 48 bits.
   function automatic longint unsigned dependency_share(input longint unsigned p,
                                                        input longint unsigned dw,
                                                        input longint unsigned q);
      longint unsigned num, quo, rem;
      num = (64'd1 << FRAC_BITS_DEF) + dw;
      quo = num / q;
      rem = num % q;
      if (quo != 0 && p > SCORE_MAX / quo) return SCORE_MAX;
      return sat48(p * quo, (p * rem) / q);
   endfunction

   // Brandes pass from one source; returns 1 when a path count saturated.
   function automatic bit brandes_pass(input int unsigned src, input int unsigned n);
      int unsigned front, back, v, u, d, lo, hi, j, k;
      longint unsigned s;
      bit sat;
      front = 0;
      back = 0;
      sat = 1'b0;
      for (k = 0; k < n; k++) begin
         reached[k] = 1'b0;
         hop_dist[k] = 0;
         sigma[k] = 0;
         delta[k] = 0;
      end
      reached[src] = 1'b1;
      sigma[src] = 1;
      bfs_queue[back++] = src;
      while (front < back) begin
         v = bfs_queue[front++];
         d = hop_dist[v];
         adjacency(v, lo, hi);
         for (j = lo; j < hi; j++) begin
            u = edge_shadow[j];
            if (u >= n) continue;
            if (!reached[u]) begin
               reached[u] = 1'b1;
               hop_dist[u] = d + 1;
               bfs_queue[back++] = u;
            end
            if (hop_dist[u] == d + 1) begin
               s = sigma[u] + sigma[v];
               if (s > PATH_MAX) begin
                  s = PATH_MAX;
                  sat = 1'b1;
               end
               sigma[u] = s;
            end
         end
      end
      while (back > 0) begin
         back--;
         v = bfs_queue[back];
         d = hop_dist[v];
         adjacency(v, lo, hi);
         for (j = lo; j < hi; j++) begin
            u = edge_shadow[j];
            if (u >= n || !reached[u]) continue;
            if (hop_dist[u] == d + 1 && sigma[u] != 0)
               delta[v] = sat48(delta[v], dependency_share(sigma[v], delta[u], sigma[u]));
         end
      end
      for (k = 0; k < n; k++)
         if (k != src) centrality[k] = sat48(centrality[k], delta[k]);
      if (run_total < 16'hFFFF) run_total++;
      return sat;
   endfunction

   function automatic answer_t predict_answer(input cmd_t c);
      answer_t a;
      int unsigned n, k;
      longint unsigned sc;
      n = active_vertices();
      a.score = '0;
      a.status = STAT_OK;
      case (c.action)
         ACT_LOAD_ROW: begin
            if (c.slot > MAX_VERTICES_DEF) a.status = STAT_RANGE;
            else row_shadow[c.slot] = c.word;
         end
         ACT_LOAD_EDGE: begin
            if (c.slot >= MAX_EDGES_DEF || c.word >= MAX_VERTICES_DEF) a.status = STAT_RANGE;
            else edge_shadow[c.slot] = c.word[VERTEX_W-1:0];
         end
         ACT_RUN: begin
            if (c.vertex >= n) a.status = STAT_RANGE;
            else if (brandes_pass(c.vertex, n)) a.status = STAT_SAT;
         end
         ACT_READ: begin
            if (c.vertex >= n) a.status = STAT_RANGE;
            else if (run_total == 0) a.status = STAT_NORUN;
            else begin
               sc = (centrality[c.vertex] * n) / run_total;
               if (sc > SCORE_MAX) sc = SCORE_MAX;
               a.score = sc[SCORE_W-1:0];
            end
         end
         ACT_CLEAR: begin
            for (k = 0; k < MAX_VERTICES_DEF; k++) centrality[k] = 0;
            run_total = 0;
         end
         default: a.status = STAT_RANGE;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      fail_count++;
   endtask

   // Monitor: check the result beat first, then predict a newly accepted command.
   always @(posedge clock) begin
      answer_t want;
      cmd_t    c;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_score !== want.score) report_mismatch("score", rsp_score, want.score);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
         end
      end
      beat_taken = !reset && start && !busy;
      if (beat_taken) begin
         c = '{req_action, req_slot, req_word, req_vertex};
         expected_answers.push_back(predict_answer(c));
      end
   end

   // Driver: bursts of back-to-back beats separated by random gaps.
   always @(negedge clock) begin
      cmd_t c;
      if (reset) begin
         gap_left <= 0;
      end else if (start && beat_taken) begin
         if (pending_cmds.size() > 0 && burst_left > 0) begin
            c = pending_cmds.pop_front();
            {req_action, req_slot, req_word, req_vertex} <= c;
            burst_left <= burst_left - 1;
         end else begin
            // Drop start and take a breath before the next burst.
            start <= 1'b0;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            {req_action, req_slot, req_word, req_vertex} <= c;
            start <= 1'b1;
            burst_left <= $urandom_range(0, 20);
         end
      end
   end

   // Cycle limit: hold the run to a bound far above the slowest legal run.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** sampled_betweenness_centrality: FAILED **");
         $finish;
      end
   end

   task automatic push_cmd(input logic [ACTION_W-1:0] act, input int unsigned sl,
                           input int unsigned wd, input int unsigned vx);
      cmd_t c;
      c.action = act;
      c.slot = sl[SLOT_W-1:0];
      c.word = wd[WORD_W-1:0];
      c.vertex = vx[VERTEX_W-1:0];
      pending_cmds.push_back(c);
   endtask

   // Register write: setup cycle, then access cycle; pready is always high.
   task automatic write_vertex_count(input int unsigned value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_VERTEX_COUNT;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      vcount_shadow = value & 32'h7FF;
   endtask

   // Wait until every beat is sent and answered and the block has settled.
   task automatic drain();
      repeat (2) begin
         while (pending_cmds.size() > 0 || start || expected_answers.size() > 0 || busy)
            @(posedge clock);
         repeat (8) @(posedge clock);
      end
   endtask

   // Random CSR graph on vertices 0..k+3; the last four have no edges so that
   // every vertex below vertex_count has its row window written.
   task automatic load_random_graph(input int unsigned k, input int unsigned base,
                                    output int unsigned edge_end);
      int unsigned cum, v, d, deg;
      cum = base;
      for (v = 0; v <= k + 3; v++) begin
         push_cmd(ACT_LOAD_ROW, v, cum, 0);
         deg = (v < k) ? $urandom_range(0, 4) : 0;
         for (d = 0; d < deg; d++) begin
            push_cmd(ACT_LOAD_EDGE, cum, $urandom_range(0, k + 2), 0);
            cum++;
         end
      end
      push_cmd(ACT_LOAD_ROW, k + 4, cum, 0);
      edge_end = cum;
   endtask

   // Mostly runs and reads, plus clears, loads (some rejected) and unknown actions.
   task automatic random_cmds(input int count, input int unsigned n,
                              input int unsigned ebase, input int unsigned eend);
      int i, r;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            push_cmd(ACT_RUN, $urandom, $urandom, $urandom_range(0, n - 1));
         else if (r < 72)
            push_cmd(ACT_READ, $urandom, $urandom,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, n - 1));
         else if (r < 75)
            push_cmd(ACT_CLEAR, $urandom, $urandom, $urandom);
         else if (r < 82 && eend > ebase)
            push_cmd(ACT_LOAD_EDGE, $urandom_range(ebase, eend - 1),
                     $urandom_range(0, 1023), 0);
         else if (r < 88)
            push_cmd(ACT_LOAD_EDGE, $urandom_range(0, 8191),
                     $urandom_range(MAX_VERTICES_DEF, 16383), 0);
         else if (r < 94)
            push_cmd(ACT_LOAD_ROW, $urandom_range(MAX_VERTICES_DEF + 1, 8191),
                     $urandom_range(0, 16383), 0);
         else
            push_cmd($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST), $urandom,
                     $urandom, $urandom);
      end
   endtask

   initial begin
      int unsigned k, base, eend, cum, v, l, ph;
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_LOAD_ROW;
      req_slot = '0;
      req_word = '0;
      req_vertex = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fail_count = 0;
      cycle_count = 0;
      beat_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      run_total = 0;
      vcount_shadow = 1;
      for (v = 0; v < MAX_VERTICES_DEF; v++) centrality[v] = 0;
      for (v = 0; v <= MAX_VERTICES_DEF; v++) row_shadow[v] = '0;
      for (v = 0; v < MAX_EDGES_DEF; v++) edge_shadow[v] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single vertex (count zero clamps to one): reads before a run, range errors
      // on the row slot, edge target and vertex, a run, unknown actions, clear.
      write_vertex_count(0);
      push_cmd(ACT_READ, 0, 0, 0);
      push_cmd(ACT_LOAD_ROW, 0, 0, 0);
      push_cmd(ACT_LOAD_ROW, 1, 0, 0);
      push_cmd(ACT_LOAD_ROW, MAX_VERTICES_DEF, 0, 0);
      push_cmd(ACT_LOAD_ROW, MAX_VERTICES_DEF - 1, 0, 0);
      push_cmd(ACT_LOAD_ROW, MAX_VERTICES_DEF + 1, 16383, 0);
      push_cmd(ACT_LOAD_ROW, 8191, 8192, 0);
      push_cmd(ACT_LOAD_EDGE, 8191, 1023, 0);
      push_cmd(ACT_LOAD_EDGE, 0, MAX_VERTICES_DEF, 0);
      push_cmd(ACT_LOAD_EDGE, 5, 16383, 0);
      push_cmd(ACT_RUN, 0, 0, 1);
      push_cmd(ACT_RUN, 0, 0, 0);
      push_cmd(ACT_READ, 0, 0, 0);
      push_cmd(ACT_READ, 0, 0, 1023);
      push_cmd(ACT_UNUSED_FIRST, 8191, 16383, 1023);
      push_cmd(ACT_UNUSED_FIRST + 1, 0, 0, 0);
      push_cmd(ACT_UNUSED_LAST, 0, 0, 0);
      push_cmd(ACT_CLEAR, 0, 0, 0);
      push_cmd(ACT_READ, 0, 0, 0);
      drain();

      // Full size (count 2047 clamps to the maximum): run and read the top vertex.
      write_vertex_count(2047);
      push_cmd(ACT_RUN, 0, 0, 1023);
      push_cmd(ACT_READ, 0, 0, 1023);
      push_cmd(ACT_READ, 0, 0, 0);
      drain();

      // Ladder of 35 two-vertex layers: path counts double per layer and saturate.
      cum = 0;
      for (v = 0; v < 70; v++) begin
         push_cmd(ACT_LOAD_ROW, v, cum, 0);
         l = v / 2;
         if (l < 34) begin
            push_cmd(ACT_LOAD_EDGE, cum, 2 * (l + 1), 0);
            push_cmd(ACT_LOAD_EDGE, cum + 1, 2 * (l + 1) + 1, 0);
            cum += 2;
         end
      end
      push_cmd(ACT_LOAD_ROW, 70, cum, 0);
      drain();
      write_vertex_count(70);
      push_cmd(ACT_RUN, 0, 0, 0);
      push_cmd(ACT_READ, 0, 0, 2);
      push_cmd(ACT_READ, 0, 0, 40);
      // Reversed and over-range offsets leave vertices with no edges.
      push_cmd(ACT_LOAD_ROW, 68, 16383, 0);
      push_cmd(ACT_LOAD_ROW, 69, 16383, 0);
      push_cmd(ACT_LOAD_ROW, 66, 135, 0);
      push_cmd(ACT_RUN, 0, 0, 66);
      push_cmd(ACT_RUN, 0, 0, 68);
      push_cmd(ACT_READ, 0, 0, 67);
      drain();

      // Random graphs, each under its own vertex count.
      for (ph = 0; ph < 4; ph++) begin
         k = $urandom_range(3, 12);
         base = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 100)
                                            : MAX_EDGES_DEF - 64;
         load_random_graph(k, base, eend);
         drain();
         write_vertex_count((ph == 0) ? 1 : $urandom_range(k - 2, k + 3));
         random_cmds(25, active_vertices(), base, eend);
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("** sampled_betweenness_centrality: PASSED **");
      end else begin
         $display("** sampled_betweenness_centrality: FAILED **");
      end
      $finish;
   end

endmodule
